@@ rtl/smmn_pkg.sv @@
package smmn_pkg;

	localparam int DATA_W   = 16;
	localparam int BINS_DEF = 64;
	localparam int QUO_W    = DATA_W + 1;
	localparam int CFG_IDX_W = 2;

	localparam logic [DATA_W-1:0] LOW_THRESH_RST  = 16'd16384;
	localparam logic [DATA_W-1:0] HIGH_THRESH_RST = 16'd49152;

	localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESH = 2'd1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MOD,
		S_RD,
		S_DIVGO,
		S_DIV,
		S_FOLD
	} state_t;

endpackage

@@ rtl/smmn_div.sv @@
// Restoring divider: quotient of (dividend << 16) / divisor, one bit a cycle.
// Needs dividend <= divisor, so the quotient fits in 17 bits.
module smmn_div
	import smmn_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] dividend,
	input  logic [DATA_W-1:0] divisor,
	output logic              busy,
	output logic [QUO_W-1:0]  quotient
);

	localparam int CNT_W = $clog2(QUO_W + 1);

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] rem_q;
	logic [QUO_W-1:0]  quo_q;
	logic [DATA_W-1:0] den_q;
	logic [DATA_W:0]   trial;
	logic              qbit;

	assign trial = {rem_q, quo_q[QUO_W-1]};
	assign qbit  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(QUO_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// bits of the dividend above the quotient range preload the remainder
			rem_q <= {1'b0, dividend[DATA_W-1:1]};
			quo_q <= {dividend[0], {(QUO_W-1){1'b0}}};
			den_q <= divisor;
		end else if (busy_q) begin
			if (qbit)
				rem_q <= DATA_W'(trial - {1'b0, den_q});
			else
				rem_q <= trial[DATA_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], qbit};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

@@ rtl/spectrum_minmax_normalizer_core.sv @@
// A bin without frame_end is accepted; the block is ready again next cycle.
// On frame_end: S_MOD reduces the rotation offset modulo the bin count,
// then each emitted bin passes store read, divider start, the 17-step shared divider,
// its finish in S_DIV, and fold; a flat frame skips the divider, and an output stall holds the fold.
// Async reset clears count, min/max, rotation and output valid and loads the default
// thresholds; the bin store is not cleared.
module spectrum_minmax_normalizer_core
	import smmn_pkg::*;
#(
	parameter int BINS = BINS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data,
	input  logic                 bin_valid,
	output logic                 bin_stall,
	input  logic [DATA_W-1:0]    magnitude,
	input  logic                 frame_end,
	input  logic                 advance_rotation,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic [DATA_W-1:0]    norm_value,
	output logic                 last_of_frame
);

	localparam int IDX_W = (BINS > 1) ? $clog2(BINS) : 1;
	localparam int CNT_W = $clog2(BINS + 1);
	localparam int SUM_W = DATA_W + 3;

	state_t state_q, state_nxt;

	logic [DATA_W-1:0] low_q, high_q;
	logic [CNT_W-1:0]  count_q, n_q, k_q, start_q;
	logic [IDX_W-1:0]  rot_q, idx_q;
	logic [DATA_W-1:0] min_q, max_q;
	logic              adv_q;
	logic [DATA_W-1:0] mem [BINS];
	logic [DATA_W-1:0] rd_q;

	logic              accept, room, flat;
	logic [CNT_W-1:0]  count_new;
	logic              div_start, div_busy;
	logic [QUO_W-1:0]  quo;
	logic              out_free, out_load, last_bin;

	logic signed [DATA_W:0]  gap, half;
	logic signed [SUM_W-1:0] qv, folded;
	logic [DATA_W-1:0]       clamped;

	assign accept    = bin_valid && !bin_stall;
	assign room      = (count_q < CNT_W'(BINS));
	assign count_new = room ? count_q + CNT_W'(1) : count_q;
	assign flat      = (max_q <= min_q);
	assign out_free  = !res_valid || !res_stall;
	assign last_bin  = (k_q == n_q - CNT_W'(1));

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= LOW_THRESH_RST;
			high_q <= HIGH_THRESH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOW_THRESH:  low_q  <= cfg_data;
				REG_HIGH_THRESH: high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// bin store
	always_ff @(posedge clk) begin
		if (accept && room)
			mem[count_q[IDX_W-1:0]] <= magnitude;
		rd_q <= mem[idx_q];
	end

	smmn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rd_q - min_q),
		.divisor  (max_q - min_q),
		.busy     (div_busy),
		.quotient (quo)
	);

	// fold toward the middle of the threshold band; half gap truncates toward zero
	always_comb begin
		gap    = $signed({1'b0, high_q}) - $signed({1'b0, low_q});
		half   = (gap + $signed({{DATA_W{1'b0}}, gap[DATA_W]})) >>> 1;
		qv     = flat ? '0 : $signed({2'b00, quo});
		folded = qv;
		if (qv < $signed({3'b000, low_q}))
			folded = qv + SUM_W'(half);
		else if (qv > $signed({3'b000, high_q}))
			folded = qv - SUM_W'(half);
		if (folded < 0)
			clamped = '0;
		else if (folded > $signed(SUM_W'(16'hFFFF)))
			clamped = '1;
		else
			clamped = folded[DATA_W-1:0];
	end

	// sequencer
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE:
				if (accept && frame_end && count_new != '0)
					state_nxt = S_MOD;
			S_MOD:
				if (start_q < n_q)
					state_nxt = S_RD;
			S_RD:
				state_nxt = S_DIVGO;
			S_DIVGO:
				state_nxt = flat ? S_FOLD : S_DIV;
			S_DIV:
				if (!div_busy)
					state_nxt = S_FOLD;
			S_FOLD:
				if (out_free)
					state_nxt = last_bin ? S_IDLE : S_RD;
			default:
				state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		bin_stall = (state_q != S_IDLE);
		div_start = (state_q == S_DIVGO) && !flat;
		out_load  = (state_q == S_FOLD) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			min_q   <= '1;
			max_q   <= '0;
			rot_q   <= '0;
		end else if (accept && room) begin
			count_q <= count_new;
			if (magnitude < min_q)
				min_q <= magnitude;
			if (magnitude > max_q)
				max_q <= magnitude;
		end else if (out_load && last_bin) begin
			count_q <= '0;
			min_q   <= '1;
			max_q   <= '0;
			if (adv_q)
				rot_q <= (start_q + CNT_W'(1) == n_q) ? '0
					: IDX_W'(start_q + CNT_W'(1));
		end
	end

	// frame emission counters
	always_ff @(posedge clk) begin
		if (accept) begin
			n_q     <= count_new;
			adv_q   <= advance_rotation;
			start_q <= CNT_W'(rot_q);
		end
		if (state_q == S_MOD) begin
			if (start_q >= n_q)
				start_q <= start_q - n_q;
			else begin
				idx_q <= IDX_W'(start_q);
				k_q   <= '0;
			end
		end
		if (out_load) begin
			k_q   <= k_q + CNT_W'(1);
			idx_q <= (CNT_W'(idx_q) + CNT_W'(1) == n_q) ? '0 : idx_q + IDX_W'(1);
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid <= 1'b0;
		else if (out_load)
			res_valid <= 1'b1;
		else if (!res_stall)
			res_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			norm_value    <= clamped;
			last_of_frame <= last_bin;
		end
	end

endmodule
